### hdl/luhn_check_digit_unit_macros.svh
// Assertion macros for the Luhn check digit unit
`ifndef LUHN_CHECK_DIGIT_UNIT_MACROS_SVH
`define LUHN_CHECK_DIGIT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LCDU_ASSERT_IMPLY(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define LCDU_ASSERT_NEXT(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define LCDU_ASSERT_IMPLY(lbl, clock, rst_n, ante, cons)
`define LCDU_ASSERT_NEXT(lbl, clock, rst_n, ante, cons)

`endif

`endif

### hdl/lcdu_pkg.sv
package lcdu_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned PROD_W     = 2 * VALUE_W;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned NUM_DIGITS = 9;
	localparam int unsigned CNT_W      = 4;

	localparam logic [VALUE_W-1:0] MAX_PAYLOAD   = 32'd99999999;
	localparam logic [VALUE_W-1:0] MAX_PROTECTED = 32'd999999999;
	localparam logic [VALUE_W-1:0] ALL_ONES      = '1;

	// floor(x/10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCCCCCD;
	localparam int unsigned        RECIP_SHIFT = 35;
	localparam int unsigned        QUOT_W      = PROD_W - RECIP_SHIFT;

	localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_VERIFY = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic first;
		logic finish;
	} dp_cmd_t;

endpackage

### hdl/lcdu_dp.sv
module lcdu_dp (
	input  logic                          clk,
	input  lcdu_pkg::dp_cmd_t             cmd,
	input  logic [1:0]                    mode,
	input  logic [lcdu_pkg::VALUE_W-1:0]  value,
	output logic [lcdu_pkg::VALUE_W-1:0]  result_value,
	output logic                          check_ok
);

	logic [lcdu_pkg::PROD_W-1:0]  prod_q;
	logic [lcdu_pkg::VALUE_W-1:0] w_q;
	logic [lcdu_pkg::VALUE_W-1:0] value_q;
	logic [lcdu_pkg::VALUE_W-1:0] payload_q;
	lcdu_pkg::mode_t              mode_q;
	logic                         range_ok_q;
	logic                         dbl_q;
	logic [lcdu_pkg::DIGIT_W-1:0] acc_q;
	logic [lcdu_pkg::DIGIT_W-1:0] last_q;
	logic [lcdu_pkg::VALUE_W-1:0] res_q;
	logic                         ok_q;

	lcdu_pkg::mode_t              mode_in;
	logic [lcdu_pkg::VALUE_W-1:0] quot;
	logic [lcdu_pkg::VALUE_W-1:0] tens;
	logic [lcdu_pkg::VALUE_W-1:0] diff;
	logic [lcdu_pkg::DIGIT_W-1:0] digit;
	logic [lcdu_pkg::DIGIT_W:0]   dbl_digit;
	logic [lcdu_pkg::DIGIT_W:0]   wdigit;
	logic [lcdu_pkg::DIGIT_W:0]   acc_sum;
	logic [lcdu_pkg::DIGIT_W-1:0] acc_next;
	logic [lcdu_pkg::DIGIT_W-1:0] check_digit;
	logic [lcdu_pkg::VALUE_W-1:0] mul_a;
	logic [lcdu_pkg::PROD_W-1:0]  prod_d;
	logic [lcdu_pkg::VALUE_W-1:0] protected_val;
	logic                         skip_sum;

	assign mode_in = lcdu_pkg::mode_t'(mode);

	// quotient and remainder of the current word by ten
	always_comb begin
		quot  = lcdu_pkg::VALUE_W'(prod_q[lcdu_pkg::PROD_W-1:lcdu_pkg::RECIP_SHIFT]);
		tens  = (quot << 3) + (quot << 1);
		diff  = w_q - tens;
		digit = diff[lcdu_pkg::DIGIT_W-1:0];
	end

	// Luhn weighting and running sum kept modulo ten
	always_comb begin
		dbl_digit = {digit, 1'b0};
		if (dbl_q) begin
			wdigit = (dbl_digit > 5'd9) ? dbl_digit - 5'd9 : dbl_digit;
		end else begin
			wdigit = {1'b0, digit};
		end
		acc_sum  = {1'b0, acc_q} + wdigit;
		acc_next = (acc_sum >= 5'd10) ? 4'(acc_sum - 5'd10) : acc_sum[lcdu_pkg::DIGIT_W-1:0];
		check_digit = (acc_q == '0) ? '0 : 4'd10 - acc_q;
		skip_sum = cmd.first && (mode_q != lcdu_pkg::MODE_ADD);
	end

	// reciprocal multiplier feeding the next digit
	always_comb begin
		mul_a  = cmd.load ? value : quot;
		prod_d = lcdu_pkg::PROD_W'(mul_a) * lcdu_pkg::PROD_W'(lcdu_pkg::RECIP_10);
		protected_val = (value_q << 3) + (value_q << 1)
			+ lcdu_pkg::VALUE_W'(check_digit);
	end

	// digit loop registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q     <= prod_d;
			w_q        <= value;
			value_q    <= value;
			mode_q     <= mode_in;
			acc_q      <= '0;
			dbl_q      <= (mode_in == lcdu_pkg::MODE_ADD);
			range_ok_q <= (mode_in == lcdu_pkg::MODE_ADD) ?
				(value <= lcdu_pkg::MAX_PAYLOAD) : (value <= lcdu_pkg::MAX_PROTECTED);
		end else if (cmd.step) begin
			prod_q <= prod_d;
			w_q    <= quot;
			dbl_q  <= ~dbl_q;
			if (skip_sum) begin
				last_q    <= digit;
				payload_q <= quot;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (mode_q)
				lcdu_pkg::MODE_ADD: begin
					res_q <= range_ok_q ? protected_val : lcdu_pkg::ALL_ONES;
					ok_q  <= range_ok_q;
				end
				lcdu_pkg::MODE_VERIFY: begin
					res_q <= '0;
					ok_q  <= range_ok_q && (check_digit == last_q);
				end
				lcdu_pkg::MODE_REMOVE: begin
					if (range_ok_q && (check_digit == last_q)) begin
						res_q <= payload_q;
						ok_q  <= 1'b1;
					end else begin
						res_q <= lcdu_pkg::ALL_ONES;
						ok_q  <= 1'b0;
					end
				end
				default: begin
					res_q <= '0;
					ok_q  <= 1'b0;
				end
			endcase
		end
	end

	assign result_value = res_q;
	assign check_ok     = ok_q;

endmodule

### hdl/lcdu_ctrl.sv
module lcdu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output lcdu_pkg::dp_cmd_t cmd
);

	lcdu_pkg::state_t               state_q, state_d;
	logic [lcdu_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic                           out_valid_q, out_valid_d;

	// state, digit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcdu_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			lcdu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = lcdu_pkg::ST_RUN;
				end
			end
			lcdu_pkg::ST_RUN: begin
				cmd.step  = 1'b1;
				cmd.first = (cnt_q == '0);
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == lcdu_pkg::LAST_DIGIT) begin
					state_d = lcdu_pkg::ST_FIN;
				end
			end
			lcdu_pkg::ST_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = lcdu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcdu_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/luhn_check_digit_unit.sv
// Luhn mod-10 check digit unit: add, verify or remove a check digit.
// Operands load at the edge that accepts the input item; nine digit steps then
// run through the divide-by-ten multiplier, and a finish step fills the output
// register once it is free. No new item is taken before that finish step, but
// the next item may enter while a finished result still waits in the output
// register.
// Reset: arst_n asynchronous, active low; clears controller and output valid.
`include "luhn_check_digit_unit_macros.svh"

module luhn_check_digit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic        check_ok
);

	lcdu_pkg::dp_cmd_t cmd;

	lcdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lcdu_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.mode         (mode),
		.value        (value),
		.result_value (result_value),
		.check_ok     (check_ok)
	);

	// busy after taking an item
	`LCDU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// a good result is never the error pattern
	`LCDU_ASSERT_IMPLY(a_ok_not_err, clk, arst_n, out_valid && check_ok, result_value != lcdu_pkg::ALL_ONES)
	// a failed result is either zero or all ones
	`LCDU_ASSERT_IMPLY(a_fail_value, clk, arst_n, out_valid && !check_ok, (result_value == '0) || (result_value == lcdu_pkg::ALL_ONES))

endmodule

### tb/sv/luhn_tb_pkg.sv
package luhn_tb_pkg;

	import lcdu_pkg::*;

	// one result item as the unit should deliver it
	typedef struct packed {
		logic [VALUE_W-1:0] number;
		logic               ok;
	} luhn_result_t;

	// Luhn check digit of a payload, doubling from the rightmost digit
	function automatic logic [3:0] luhn_digit_of(input logic [VALUE_W-1:0] payload);
		logic [VALUE_W-1:0] rest;
		int unsigned        sum;
		int unsigned        d;
		bit                 dbl;
		rest = payload;
		sum  = 0;
		dbl  = 1'b1;
		while (rest != 0) begin
			d    = rest % 10;
			rest = rest / 10;
			if (dbl) begin
				d = d * 2;
				if (d > 9)
					d = d - 9;
			end
			sum = sum + d;
			dbl = !dbl;
		end
		return 4'((sum * 9) % 10);
	endfunction

endpackage

### tb/sv/luhn_result_checker.sv
module luhn_result_checker
	import lcdu_pkg::*;
	import luhn_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] result_value,
	input  logic        check_ok,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          results_ok
);

	luhn_result_t expected_results[$];

	int n_fail    = 0;
	int n_pending = 0;
	int n_seen    = 0;
	int n_ok      = 0;

	// expected result of one item; the unit is a pure function of it
	function automatic luhn_result_t predict_result(input mode_t op,
		input logic [VALUE_W-1:0] v);
		luhn_result_t       r;
		logic [VALUE_W-1:0] payload;
		logic [3:0]         last;
		payload  = v / 10;
		last     = 4'(v % 10);
		r.number = '0;
		r.ok     = 1'b0;
		case (op)
			MODE_ADD: begin
				if (v > MAX_PAYLOAD) begin
					r.number = ALL_ONES;
				end else begin
					r.number = VALUE_W'(v * 10 + luhn_digit_of(v));
					r.ok     = 1'b1;
				end
			end
			MODE_VERIFY: begin
				r.ok = (v <= MAX_PROTECTED) && (luhn_digit_of(payload) == last);
			end
			MODE_REMOVE: begin
				if (payload > MAX_PAYLOAD) begin
					r.number = ALL_ONES;
				end else if (luhn_digit_of(payload) == last) begin
					r.number = payload;
					r.ok     = 1'b1;
				end else begin
					r.number = ALL_ONES;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	assign fail_count   = n_fail;
	assign pending      = n_pending;
	assign results_seen = n_seen;
	assign results_ok   = n_ok;

	// watch both channels at the rising edge
	always @(posedge clk) begin
		luhn_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_result(mode_t'(mode), value));
			if (out_valid && !out_stall) begin
				n_seen++;
				if (check_ok)
					n_ok++;
				if (expected_results.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected result item, result_value %h check_ok %b",
						$time, result_value, check_ok);
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want.number) begin
						n_fail++;
						$display("%0t: result_value mismatch, expected %h actual %h",
							$time, want.number, result_value);
					end
					if (check_ok !== want.ok) begin
						n_fail++;
						$display("%0t: check_ok mismatch, expected %b actual %b",
							$time, want.ok, check_ok);
					end
				end
			end
			n_pending = expected_results.size();
		end
	end

endmodule

### tb/sv/tb_luhn_check_digit_unit.sv
module tb_luhn_check_digit_unit;

	import lcdu_pkg::*;
	import luhn_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int MAX_GAP      = 18;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 30;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  mode         = 2'd0;
	logic [31:0] value        = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [31:0] result_value;
	logic        check_ok;

	int chk_fails;
	int chk_pending;
	int chk_seen;
	int chk_ok;

	bit calm = 1'b0;
	int mode_count[4];
	int idle_cycles = 0;

	luhn_check_digit_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.check_ok     (check_ok)
	);

	luhn_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.check_ok     (check_ok),
		.fail_count   (chk_fails),
		.pending      (chk_pending),
		.results_seen (chk_seen),
		.results_ok   (chk_ok)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// idle cycles before the next item, none during calm stretches
	function automatic int draw_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// payload of up to eight digits, weighted towards short and extreme ones
	function automatic logic [31:0] draw_payload();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return MAX_PAYLOAD;
			2, 3:    return $urandom_range(0, 999);
			4:       return $urandom_range(0, 99999);
			default: return $urandom_range(0, MAX_PAYLOAD);
		endcase
	endfunction

	// values around the range boundaries and near all ones, or fully random words
	function automatic logic [31:0] draw_noise();
		case ($urandom_range(0, 5))
			0:       return MAX_PAYLOAD + $urandom_range(0, 20) - 10;
			1:       return MAX_PROTECTED + $urandom_range(0, 20) - 10;
			2:       return ALL_ONES - $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// drive one item at the falling edge and hold it until accepted
	task automatic send_item(input mode_t m, input logic [31:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode     <= m;
		value    <= v;
		in_valid <= 1'b1;
		mode_count[m]++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// result side: random stall before each item
	initial begin
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// no item moving on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("luhn_check_digit_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		mode_t       m;
		logic [31:0] p;
		logic [31:0] v;
		logic [3:0]  d;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: range edges, every mode, good and bad digits
		send_item(MODE_ADD, 32'd0);
		send_item(MODE_ADD, 32'd1);
		send_item(MODE_ADD, 32'd7992739);
		send_item(MODE_ADD, MAX_PAYLOAD);
		send_item(MODE_ADD, MAX_PAYLOAD + 1);
		send_item(MODE_ADD, ALL_ONES);
		send_item(MODE_VERIFY, 32'd0);
		send_item(MODE_VERIFY, 32'd5);
		send_item(MODE_VERIFY, MAX_PAYLOAD * 10 + luhn_digit_of(MAX_PAYLOAD));
		send_item(MODE_VERIFY, MAX_PROTECTED);
		send_item(MODE_VERIFY, MAX_PROTECTED + 1);
		send_item(MODE_VERIFY, ALL_ONES);
		send_item(MODE_VERIFY, 32'd79927398 * 10 + luhn_digit_of(32'd79927398));
		send_item(MODE_REMOVE, 32'd0);
		send_item(MODE_REMOVE, 32'd9);
		send_item(MODE_REMOVE, MAX_PAYLOAD * 10 + luhn_digit_of(MAX_PAYLOAD));
		send_item(MODE_REMOVE, MAX_PROTECTED);
		send_item(MODE_REMOVE, MAX_PROTECTED + 1);
		send_item(MODE_REMOVE, ALL_ONES);
		send_item(MODE_REMOVE, 32'd12345 * 10 + ((luhn_digit_of(32'd12345) + 1) % 10));
		send_item(MODE_NONE, 32'd0);
		send_item(MODE_NONE, ALL_ONES);
		send_item(MODE_NONE, 32'h5555_AAAA);

		// random: mostly well-formed numbers, some wrong digits and noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = ((i / 150) % 4) == 1;
			case ($urandom_range(0, 9))
				0, 1, 2: m = MODE_ADD;
				3, 4, 5: m = MODE_VERIFY;
				6, 7, 8: m = MODE_REMOVE;
				default: m = MODE_NONE;
			endcase
			p = draw_payload();
			d = luhn_digit_of(p);
			case ($urandom_range(0, 9))
				0, 1:    v = draw_noise();
				2, 3:    v = p * 10 + ((d + $urandom_range(1, 9)) % 10);
				default: v = (m == MODE_ADD) ? p : p * 10 + d;
			endcase
			send_item(m, v);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain outstanding results, then allow for latency
		while (chk_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d add, %0d verify, %0d remove, %0d unused-mode items",
			mode_count[MODE_ADD], mode_count[MODE_VERIFY], mode_count[MODE_REMOVE],
			mode_count[MODE_NONE]);
		$display("checked %0d results, %0d with check_ok set, %0d mismatches",
			chk_seen, chk_ok, chk_fails);
		if (chk_fails == 0) begin
			$display("luhn_check_digit_unit regression: pass");
		end else begin
			$display("luhn_check_digit_unit regression: fail");
		end
		$finish;
	end

endmodule
